>>> hdl/hst_pkg.sv
// Package with the shared types and codes of the handle slot table.
package hst_pkg;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_SET_EN = 3'd2,
    ACT_READ   = 3'd3,
    ACT_LOOKUP = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_OFF     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_LIST_PTR,
    FSM_LIST_SLOT
  } fsm_e;

  localparam logic [1:0] KIND_SPOT = 2'd2;

  typedef struct packed {
    logic [31:0] handle;
    logic [1:0]  kind;
    logic        shadow;
    logic        enabled;
  } slot_entry_t;

endpackage

>>> hdl/hst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module hst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/handle_slot_table.sv
// Top level of the handle slot table: slot memory, packed active list and sequencer.
//
// Add, remove, set enabled and lookup each run one pass over the slot memory, one slot
// per cycle through its read port, which also rebuilds the packed active list: busy is
// high for the whole pass, and the result strobe is registered with the return to idle.
// A read of the active list passes two busy states (packed list read, then slot read).
// Actions while the system is off, unknown actions and list positions at or beyond the
// count are answered in the cycle after the transfer, busy staying low. The result is
// shown for one cycle under done_o and cannot be held off; a new start is taken in that
// same cycle. Reset and every write of the on register clear the table at once.
module handle_slot_table #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] handle_i,
  input  logic [1:0]  light_kind_i,
  input  logic        shadow_flag_i,
  input  logic        enable_value_i,
  input  logic [3:0]  list_position_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] result_handle_o,
  output logic [3:0]  slot_index_o,
  output logic [4:0]  active_total_o,
  output logic [1:0]  entry_kind_o,
  output logic        entry_shadow_o,
  output logic        entry_enabled_o
);

  import hst_pkg::*;

  localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int EW = $bits(slot_entry_t);

  fsm_e                   state_q, state_d;
  logic                   sys_on_q, sys_on_d;
  logic [TABLE_SLOTS-1:0] valid_q, valid_d;
  logic [31:0]            next_h_q, next_h_d, next_h_inc;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          run_q, run_d;
  logic [SW:0]            addr_q, addr_d;
  logic                   proc_q, proc_d;
  logic [SW-1:0]          pidx_q, pidx_d;
  logic                   found_q, found_d;
  action_e                act_q, act_d;
  logic [31:0]            h_q, h_d;
  logic [1:0]             kind_q, kind_d;
  logic                   shadow_q, shadow_d;
  logic                   en_q, en_d;
  logic                   done_q, done_d;
  status_e                rstat_q, rstat_d;
  slot_entry_t            rent_q, rent_d;
  logic [SW-1:0]          rslot_q, rslot_d;

  logic                   slot_we;
  logic [SW-1:0]          slot_waddr, slot_raddr;
  slot_entry_t            slot_wdata, slot_rdata, ent, upd;
  logic                   pk_we;
  logic [SW-1:0]          pk_waddr, pk_raddr, pk_wdata, pk_rdata;
  logic                   occ, match, first, post_occ, post_en, found_now;

  hst_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  hst_ram #(.WIDTH(SW), .DEPTH(TABLE_SLOTS)) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (pk_we),
    .waddr_i (pk_waddr),
    .wdata_i (pk_wdata),
    .raddr_i (pk_raddr),
    .rdata_o (pk_rdata)
  );

  assign pk_raddr   = SW'(list_position_i);
  assign slot_raddr = (state_q == FSM_LIST_PTR) ? pk_rdata : addr_q[SW-1:0];
  assign next_h_inc = (next_h_q == 32'hFFFF_FFFF) ? 32'd1 : next_h_q + 32'd1;

  always_comb begin
    state_d    = state_q;
    sys_on_d   = sys_on_q;
    valid_d    = valid_q;
    next_h_d   = next_h_q;
    count_d    = count_q;
    run_d      = run_q;
    addr_d     = addr_q;
    proc_d     = 1'b0;
    pidx_d     = pidx_q;
    found_d    = found_q;
    act_d      = act_q;
    h_d        = h_q;
    kind_d     = kind_q;
    shadow_d   = shadow_q;
    en_d       = en_q;
    done_d     = 1'b0;
    rstat_d    = rstat_q;
    rent_d     = rent_q;
    rslot_d    = rslot_q;
    slot_we    = 1'b0;
    slot_waddr = pidx_q;
    slot_wdata = '0;
    pk_we      = 1'b0;
    pk_waddr   = run_q[SW-1:0];
    pk_wdata   = pidx_q;
    ent        = valid_q[pidx_q] ? slot_rdata : '0;
    occ        = valid_q[pidx_q];
    upd        = ent;
    match      = 1'b0;
    first      = 1'b0;
    post_occ   = 1'b0;
    post_en    = 1'b0;
    found_now  = found_q;

    case (state_q)
      FSM_IDLE: begin
        if (start_i) begin
          rent_d  = '0;
          rslot_d = '0;
          if (!sys_on_q) begin
            rstat_d = ST_OFF;
            done_d  = 1'b1;
          end else begin
            case (action_e'(action_i))
              ACT_ADD, ACT_REMOVE, ACT_SET_EN, ACT_LOOKUP: begin
                state_d  = FSM_SCAN;
                act_d    = action_e'(action_i);
                h_d      = handle_i;
                kind_d   = (light_kind_i > KIND_SPOT) ? KIND_SPOT : light_kind_i;
                shadow_d = shadow_flag_i;
                en_d     = enable_value_i;
                addr_d   = '0;
                found_d  = 1'b0;
                run_d    = '0;
                rstat_d  = ST_MISSING;
              end
              ACT_READ: begin
                if (32'(list_position_i) >= 32'(count_q) ||
                    32'(list_position_i) >= 32'(TABLE_SLOTS)) begin
                  rstat_d = ST_MISSING;
                  done_d  = 1'b1;
                end else begin
                  state_d = FSM_LIST_PTR;
                end
              end
              default: begin
                rstat_d = ST_MISSING;
                done_d  = 1'b1;
              end
            endcase
          end
        end
      end
      FSM_SCAN: begin
        if (addr_q < (SW + 1)'(TABLE_SLOTS)) begin
          addr_d = addr_q + 1'b1;
          proc_d = 1'b1;
          pidx_d = addr_q[SW-1:0];
        end
        if (proc_q) begin
          if (act_q == ACT_ADD) begin
            match = !occ;
          end else begin
            match = occ && (ent.handle == h_q) && (h_q != '0);
          end
          first    = match && !found_q;
          post_occ = occ;
          post_en  = ent.enabled;
          if (first) begin
            found_d = 1'b1;
            rslot_d = pidx_q;
            rstat_d = ST_OK;
            case (act_q)
              ACT_ADD: begin
                upd.handle  = next_h_q;
                upd.kind    = kind_q;
                upd.shadow  = shadow_q;
                upd.enabled = 1'b1;
                slot_we     = 1'b1;
                slot_wdata  = upd;
                valid_d[pidx_q] = 1'b1;
                next_h_d    = next_h_inc;
                post_occ    = 1'b1;
                post_en     = 1'b1;
                rent_d      = upd;
              end
              ACT_REMOVE: begin
                valid_d[pidx_q] = 1'b0;
                post_occ    = 1'b0;
                rent_d      = ent;
              end
              ACT_SET_EN: begin
                upd.enabled = en_q;
                slot_we     = 1'b1;
                slot_wdata  = upd;
                post_en     = en_q;
                rent_d      = upd;
              end
              default: begin
                rent_d      = ent;
              end
            endcase
          end
          if (post_occ && post_en) begin
            pk_we = 1'b1;
            run_d = run_q + 1'b1;
          end
          found_now = found_q || first;
          if (pidx_q == SW'(TABLE_SLOTS - 1)) begin
            count_d = run_d;
            done_d  = 1'b1;
            state_d = FSM_IDLE;
            if (!found_now) begin
              rstat_d = (act_q == ACT_ADD) ? ST_FULL : ST_MISSING;
            end
          end
        end
      end
      FSM_LIST_PTR: begin
        pidx_d  = pk_rdata;
        state_d = FSM_LIST_SLOT;
      end
      FSM_LIST_SLOT: begin
        rent_d  = ent;
        rslot_d = pidx_q;
        rstat_d = ST_OK;
        done_d  = 1'b1;
        state_d = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      sys_on_d = cfg_data_i;
      valid_d  = '0;
      next_h_d = 32'd1;
      count_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      sys_on_q <= 1'b0;
      valid_q  <= '0;
      next_h_q <= 32'd1;
      count_q  <= '0;
      run_q    <= '0;
      addr_q   <= '0;
      proc_q   <= 1'b0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      sys_on_q <= sys_on_d;
      valid_q  <= valid_d;
      next_h_q <= next_h_d;
      count_q  <= count_d;
      run_q    <= run_d;
      addr_q   <= addr_d;
      proc_q   <= proc_d;
      found_q  <= found_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q   <= pidx_d;
    act_q    <= act_d;
    h_q      <= h_d;
    kind_q   <= kind_d;
    shadow_q <= shadow_d;
    en_q     <= en_d;
    rstat_q  <= rstat_d;
    rent_q   <= rent_d;
    rslot_q  <= rslot_d;
  end

  assign busy_o          = (state_q != FSM_IDLE);
  assign done_o          = done_q;
  assign status_o        = rstat_q;
  assign result_handle_o = rent_q.handle;
  assign slot_index_o    = 4'(rslot_q);
  assign active_total_o  = 5'(count_q);
  assign entry_kind_o    = rent_q.kind;
  assign entry_shadow_o  = rent_q.shadow;
  assign entry_enabled_o = rent_q.enabled;

  // A result only appears once the sequencer has returned to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(active_total_o) <= 32'(TABLE_SLOTS)))
    else $error("active total exceeds table size");

  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_OFF) |-> (result_handle_o == '0 && active_total_o == '0))
    else $error("system off result carries data");

  a_ok_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_OK) |-> (result_handle_o != '0))
    else $error("successful result with zero handle");

endmodule

>>> sim/tb_handle_slot_table.sv
// Self-checking testbench for the handle slot table with a predictor of the slot memory.
module tb_handle_slot_table;
  timeunit 1ns;
  timeprecision 1ps;

  import hst_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [1:0] KIND_DIR   = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd3;
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  localparam int PHASES = 5;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] handle;
    logic [1:0]  kind;
    logic        shadow;
    logic        en;
    logic [3:0]  pos;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] handle;
    logic [3:0]  slot;
    logic [4:0]  total;
    logic [1:0]  kind;
    logic        shadow;
    logic        enabled;
  } reply_t;

  typedef struct {
    bit     wr_cfg;
    bit     cfg_val;
    cmd_t   cmd;
    bit     typed;
    reply_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_data_i = 1'b0;
  logic        start_i = 1'b0;
  logic [2:0]  action_i = '0;
  logic [31:0] handle_i = '0;
  logic [1:0]  light_kind_i = '0;
  logic        shadow_flag_i = 1'b0;
  logic        enable_value_i = 1'b0;
  logic [3:0]  list_position_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] result_handle_o;
  logic [3:0]  slot_index_o;
  logic [4:0]  active_total_o;
  logic [1:0]  entry_kind_o;
  logic        entry_shadow_o;
  logic        entry_enabled_o;

  slot_entry_t mirror_slot [SLOTS];
  logic [3:0]  mirror_list [SLOTS];
  logic [4:0]  mirror_count;
  logic [31:0] mirror_next;
  bit          mirror_on;

  reply_t   pending_replies[$];
  dir_row_t dir_rows[$];
  int       mismatches = 0;

  int phase_on    [PHASES] = '{1, 1, 0, 1, 1};
  int phase_idle  [PHASES] = '{0, 73, 28, 28, 0};
  int phase_items [PHASES] = '{440, 440, 60, 400, 410};

  handle_slot_table #(.TABLE_SLOTS(SLOTS)) i_dut (.*);

  always begin
    #5;
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
  end

  initial begin
    #(5_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void clear_mirror();
    for (int i = 0; i < SLOTS; i++) begin
      mirror_slot[i] = '0;
      mirror_list[i] = '0;
    end
    mirror_count = '0;
    mirror_next  = 32'd1;
  endfunction

  function automatic void rebuild_list();
    mirror_count = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (mirror_slot[i].handle != '0 && mirror_slot[i].enabled) begin
        mirror_list[mirror_count] = 4'(i);
        mirror_count++;
      end
    end
  endfunction

  function automatic int slot_of(input logic [31:0] h);
    int s;
    s = SLOTS;
    if (h != '0) begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (mirror_slot[i].handle == h) s = i;
      end
    end
    return s;
  endfunction

  function automatic reply_t slot_reply(input int s);
    reply_t r;
    r = '0;
    r.status  = ST_OK;
    r.handle  = mirror_slot[s].handle;
    r.slot    = 4'(s);
    r.kind    = mirror_slot[s].kind;
    r.shadow  = mirror_slot[s].shadow;
    r.enabled = mirror_slot[s].enabled;
    return r;
  endfunction

  function automatic reply_t table_action(input cmd_t c);
    reply_t r;
    int s;
    r = '0;
    r.status = ST_MISSING;
    if (!mirror_on) begin
      r.status = ST_OFF;
      return r;
    end
    case (c.action)
      ACT_ADD: begin
        s = slot_of('0);
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (mirror_slot[i].handle == '0) s = i;
        end
        if (s == SLOTS) begin
          r.status = ST_FULL;
        end else begin
          mirror_slot[s].handle  = mirror_next;
          mirror_slot[s].kind    = (c.kind == KIND_BAD) ? KIND_SPOT : c.kind;
          mirror_slot[s].shadow  = c.shadow;
          mirror_slot[s].enabled = 1'b1;
          mirror_next = mirror_next + 32'd1;
          if (mirror_next == '0) mirror_next = 32'd1;
          rebuild_list();
          r = slot_reply(s);
        end
      end
      ACT_REMOVE: begin
        s = slot_of(c.handle);
        if (s != SLOTS) begin
          r = slot_reply(s);
          mirror_slot[s] = '0;
          rebuild_list();
        end
      end
      ACT_SET_EN: begin
        s = slot_of(c.handle);
        if (s != SLOTS) begin
          mirror_slot[s].enabled = c.en;
          rebuild_list();
          r = slot_reply(s);
        end
      end
      ACT_READ: begin
        if (c.pos < mirror_count) r = slot_reply(mirror_list[c.pos]);
      end
      ACT_LOOKUP: begin
        s = slot_of(c.handle);
        if (s != SLOTS) r = slot_reply(s);
      end
      default: r.status = ST_MISSING;
    endcase
    r.total = mirror_count;
    return r;
  endfunction

  function automatic dir_row_t mk_row(input bit wr, input bit on, input logic [2:0] act,
                                      input logic [31:0] h, input logic [1:0] k,
                                      input logic sh, input logic en, input logic [3:0] pos,
                                      input bit typed, input status_e st,
                                      input logic [31:0] rh, input logic [3:0] rs,
                                      input logic [4:0] rt, input logic [1:0] rk,
                                      input logic rsh, input logic ren);
    dir_row_t row;
    row.wr_cfg       = wr;
    row.cfg_val      = on;
    row.cmd.action   = act;
    row.cmd.handle   = h;
    row.cmd.kind     = k;
    row.cmd.shadow   = sh;
    row.cmd.en       = en;
    row.cmd.pos      = pos;
    row.typed        = typed;
    row.want.status  = st;
    row.want.handle  = rh;
    row.want.slot    = rs;
    row.want.total   = rt;
    row.want.kind    = rk;
    row.want.shadow  = rsh;
    row.want.enabled = ren;
    return row;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    c.kind   = 2'($urandom_range(3, 0));
    c.shadow = 1'($urandom_range(1, 0));
    c.en     = 1'($urandom_range(1, 0));
    if (mirror_count != '0 && $urandom_range(99, 0) < 70) begin
      c.pos = 4'($urandom_range(int'(mirror_count) - 1, 0));
    end else begin
      c.pos = 4'($urandom_range(15, 0));
    end
    pick = $urandom_range(99, 0);
    if (pick < 60) begin
      c.handle = mirror_slot[$urandom_range(SLOTS - 1, 0)].handle;
    end else if (pick < 75) begin
      c.handle = mirror_next - 32'($urandom_range(20, 1));
    end else if (pick < 82) begin
      c.handle = '0;
    end else begin
      c.handle = $urandom();
    end
    pick = $urandom_range(99, 0);
    if (pick < 35) begin
      c.action = ACT_ADD;
    end else if (pick < 50) begin
      c.action = ACT_REMOVE;
    end else if (pick < 65) begin
      c.action = ACT_SET_EN;
    end else if (pick < 80) begin
      c.action = ACT_READ;
    end else if (pick < 95) begin
      c.action = ACT_LOOKUP;
    end else begin
      c.action = 3'($urandom_range(7, 0));
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // Entered at a falling edge on which start_i has not been assigned yet.
  task automatic apply_item(input cmd_t c, input int idle_pct, input bit typed,
                            input reply_t want);
    reply_t got;
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i         <= 1'b1;
    action_i        <= c.action;
    handle_i        <= c.handle;
    light_kind_i    <= c.kind;
    shadow_flag_i   <= c.shadow;
    enable_value_i  <= c.en;
    list_position_i <= c.pos;
    do @(posedge clk_i); while (busy_o);
    got = table_action(c);
    pending_replies.push_back(typed ? want : got);
    @(negedge clk_i);
  endtask

  task automatic write_on(input bit value);
    start_i <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    mirror_on = value;
    clear_mirror();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    reply_t w;
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("result transfer with nothing pending");
      end else begin
        w = pending_replies.pop_front();
        check_field("status", 32'(status_o), 32'(w.status));
        check_field("result_handle", result_handle_o, w.handle);
        check_field("slot_index", 32'(slot_index_o), 32'(w.slot));
        check_field("active_total", 32'(active_total_o), 32'(w.total));
        check_field("entry_kind", 32'(entry_kind_o), 32'(w.kind));
        check_field("entry_shadow", 32'(entry_shadow_o), 32'(w.shadow));
        check_field("entry_enabled", 32'(entry_enabled_o), 32'(w.enabled));
      end
    end
  end

  initial begin
    reply_t no_reply;
    no_reply  = '0;
    mirror_on = 1'b0;
    clear_mirror();

    // The table starts off, so the first rows must fail before the register is written.
    dir_rows.push_back(mk_row(0, 0, ACT_ADD, 32'd0, KIND_DIR, 0, 0, 4'd0,
                              1, ST_OFF, 32'd0, 4'd0, 5'd0, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(0, 0, ACT_LOOKUP, 32'd1, KIND_DIR, 0, 0, 4'd0,
                              1, ST_OFF, 32'd0, 4'd0, 5'd0, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(1, 1, ACT_READ, 32'd0, KIND_DIR, 0, 0, 4'd0,
                              1, ST_MISSING, 32'd0, 4'd0, 5'd0, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(0, 0, ACT_ADD, 32'd0, KIND_DIR, 0, 0, 4'd0,
                              1, ST_OK, 32'd1, 4'd0, 5'd1, KIND_DIR, 0, 1));
    dir_rows.push_back(mk_row(0, 0, ACT_ADD, 32'hFFFF_FFFF, KIND_BAD, 1, 1, 4'd15,
                              1, ST_OK, 32'd2, 4'd1, 5'd2, KIND_SPOT, 1, 1));
    dir_rows.push_back(mk_row(0, 0, ACT_ADD, 32'd0, KIND_POINT, 0, 0, 4'd0,
                              1, ST_OK, 32'd3, 4'd2, 5'd3, KIND_POINT, 0, 1));
    dir_rows.push_back(mk_row(0, 0, ACT_LOOKUP, 32'd0, KIND_DIR, 0, 0, 4'd0,
                              1, ST_MISSING, 32'd0, 4'd0, 5'd3, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(0, 0, ACT_LOOKUP, 32'hFFFF_FFFF, KIND_DIR, 0, 0, 4'd0,
                              1, ST_MISSING, 32'd0, 4'd0, 5'd3, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(0, 0, ACT_LOOKUP, 32'd2, KIND_DIR, 0, 0, 4'd0,
                              0, ST_OK, 32'd0, 4'd0, 5'd0, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(0, 0, ACT_SET_EN, 32'd2, KIND_DIR, 0, 0, 4'd0,
                              0, ST_OK, 32'd0, 4'd0, 5'd0, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(0, 0, ACT_READ, 32'd0, KIND_DIR, 0, 0, 4'd1,
                              0, ST_OK, 32'd0, 4'd0, 5'd0, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(0, 0, ACT_READ, 32'd0, KIND_DIR, 0, 0, 4'd15,
                              1, ST_MISSING, 32'd0, 4'd0, 5'd2, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(0, 0, ACT_REMOVE, 32'd1, KIND_DIR, 0, 0, 4'd0,
                              0, ST_OK, 32'd0, 4'd0, 5'd0, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(0, 0, ACT_REMOVE, 32'd1, KIND_DIR, 0, 0, 4'd0,
                              0, ST_OK, 32'd0, 4'd0, 5'd0, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(0, 0, ACT_ADD, 32'd0, KIND_POINT, 1, 0, 4'd0,
                              0, ST_OK, 32'd0, 4'd0, 5'd0, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(0, 0, ACT_UNUSED_LO, 32'd2, KIND_DIR, 0, 0, 4'd0,
                              0, ST_OK, 32'd0, 4'd0, 5'd0, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(0, 0, ACT_UNUSED_HI, 32'd3, KIND_BAD, 1, 1, 4'd15,
                              0, ST_OK, 32'd0, 4'd0, 5'd0, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(0, 0, ACT_SET_EN, 32'd2, KIND_DIR, 0, 1, 4'd0,
                              0, ST_OK, 32'd0, 4'd0, 5'd0, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(0, 0, ACT_READ, 32'd0, KIND_DIR, 0, 0, 4'd0,
                              0, ST_OK, 32'd0, 4'd0, 5'd0, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(1, 0, ACT_ADD, 32'd0, KIND_DIR, 0, 0, 4'd0,
                              1, ST_OFF, 32'd0, 4'd0, 5'd0, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(1, 1, ACT_LOOKUP, 32'd2, KIND_DIR, 0, 0, 4'd0,
                              1, ST_MISSING, 32'd0, 4'd0, 5'd0, KIND_DIR, 0, 0));
    dir_rows.push_back(mk_row(0, 0, ACT_ADD, 32'd0, KIND_POINT, 1, 0, 4'd0,
                              1, ST_OK, 32'd1, 4'd0, 5'd1, KIND_POINT, 1, 1));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_cfg) write_on(dir_rows[i].cfg_val);
      apply_item(dir_rows[i].cmd, 0, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_on(phase_on[p] != 0);
      for (int n = 0; n < phase_items[p]; n++) begin
        apply_item(random_cmd(), phase_idle[p], 1'b0, no_reply);
      end
    end

    start_i <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
